// ===== hw/rtl/htfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// htfc_pkg: shared definitions for the sensor frame check and convert unit
// Error codes, scaling constants and the CRC-8 (poly 0x31) byte update.
// ----------------------------------------------------------------------------
package htfc_pkg;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_STATUS = 2'd1,
        ERR_CRC    = 2'd2
    } err_code_t;

    // Channel kinds
    localparam logic KIND_HUM  = 1'b0;
    localparam logic KIND_TEMP = 1'b1;

    // CRC-8 polynomial x^8+x^5+x^4+1 and status mask
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [1:0] STATUS_BITS = 2'b11;

    // Gain split as gain = FULL_SCALE * quot + rem, with FULL_SCALE = 65535
    localparam logic [15:0] FULL_SCALE = 16'd65535;
    localparam logic [11:0] HUM_QUOT   = 12'd1907;
    localparam logic [14:0] HUM_REM    = 15'd24755;
    localparam logic [11:0] TEMP_QUOT  = 12'd2681;
    localparam logic [14:0] TEMP_REM   = 15'd20665;

    // Offsets in micro-units
    localparam logic [27:0] HUM_OFFSET  = 28'd6000000;
    localparam logic [27:0] TEMP_OFFSET = 28'd46850000;

    // Split into whole and millionths: floor(2^40 / 1e6) as reciprocal
    localparam logic [19:0] MICRO_SCALE = 20'd1000000;
    localparam logic [20:0] MICRO_RECIP = 21'd1099511;
    localparam int          RECIP_SHIFT = 40;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (crc[7])
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/humidity_temp_frame_check_convert_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_unit: sensor frame check and convert
// Checks a three-byte humidity or temperature frame (status bits, CRC-8)
// and scales the raw word to a signed whole part and millionths part.
// ----------------------------------------------------------------------------
// The unit takes one frame per clock when the output side is ready and
// returns one result per frame, in order. It has seven register stages:
// input register, gain products, the division by 65535, offset and
// magnitude, the reciprocal product for the split by one million, the
// remainder, and the result register. Each stage moves on as soon as the
// stage after it has room, so a stalled output only holds the frames
// behind it.
module humidity_temp_frame_check_convert_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [7:0] data_high, [15:8] data_low, [23:16] check_byte
    input  wire logic [23:0] s_axis_tdata,
    // [0] kind
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] error_code, [17:2] raw_word, [26:18] whole_part, [47:27] micro_part
    output      logic [47:0] m_axis_tdata
);
    import htfc_pkg::*;

    localparam int NSTG = 7;

    // Stage handshake
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] take;

    // Stage 0: input register
    logic        kind0_reg;
    logic [7:0]  hi0_reg;
    logic [7:0]  lo0_reg;
    logic [7:0]  chk0_reg;

    // Stage 1: checks and gain products
    logic [1:0]  err1_reg,  err1_next;
    logic [15:0] raw1_reg,  raw1_next;
    logic        kind1_reg;
    logic [27:0] pa1_reg,   pa1_next;
    logic [30:0] pb1_reg,   pb1_next;

    // Stage 2: quotient by 65535
    logic [1:0]  err2_reg;
    logic [15:0] raw2_reg;
    logic        kind2_reg;
    logic [27:0] q2_reg,    q2_next;

    // Stage 3: offset, sign and magnitude
    logic [1:0]  err3_reg;
    logic [15:0] raw3_reg;
    logic        neg3_reg,  neg3_next;
    logic [26:0] mag3_reg,  mag3_next;

    // Stage 4: whole estimate
    logic [1:0]  err4_reg;
    logic [15:0] raw4_reg;
    logic        neg4_reg;
    logic [26:0] mag4_reg;
    logic [7:0]  w4_reg,    w4_next;

    // Stage 5: remainder
    logic [1:0]  err5_reg;
    logic [15:0] raw5_reg;
    logic        neg5_reg;
    logic [7:0]  w5_reg;
    logic [20:0] r5_reg,    r5_next;

    // Stage 6: result register
    logic [1:0]  err6_reg,  err6_next;
    logic [15:0] raw6_reg;
    logic [8:0]  whole6_reg, whole6_next;
    logic [20:0] micro6_reg, micro6_next;

    // Backpressure: a stage takes a new request when empty or emptying
    always_comb
    begin
        logic go;
        take[NSTG-1] = !valid_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            go = valid_reg[i] && take[i+1];
            take[i] = !valid_reg[i] || go;
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (take[i])
                valid_next[i] = (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            else
                valid_next[i] = valid_reg[i];
        end
    end

    assign s_axis_tready = take[0];
    assign m_axis_tvalid = valid_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Stage 1: status test, CRC and the two gain products
    always_comb
    begin
        logic [7:0]  crc;
        logic [11:0] gq;
        logic [14:0] gr;
        crc = crc8_byte(crc8_byte(8'h00, hi0_reg), lo0_reg);
        if (lo0_reg[1:0] == STATUS_BITS)
            err1_next = ERR_STATUS;
        else if (crc != chk0_reg)
            err1_next = ERR_CRC;
        else
            err1_next = ERR_OK;
        raw1_next = {hi0_reg, lo0_reg};
        gq = (kind0_reg == KIND_TEMP) ? TEMP_QUOT : HUM_QUOT;
        gr = (kind0_reg == KIND_TEMP) ? TEMP_REM  : HUM_REM;
        pa1_next = {16'd0, gq} * {12'd0, raw1_next};
        pb1_next = {16'd0, gr} * {15'd0, raw1_next};
    end

    // Stage 2: floor(pb / 65535) = hi + carry, hi + lo below twice 65535
    always_comb
    begin
        logic [16:0] s;
        logic        inc;
        s   = {2'd0, pb1_reg[30:16]} + {1'b0, pb1_reg[15:0]};
        inc = (s >= {1'b0, FULL_SCALE});
        q2_next = pa1_reg + {13'd0, pb1_reg[30:16]} + {27'd0, inc};
    end

    // Stage 3: subtract offset, split into sign and magnitude
    always_comb
    begin
        logic [28:0] v;
        logic [27:0] off;
        off = (kind2_reg == KIND_TEMP) ? TEMP_OFFSET : HUM_OFFSET;
        v = {1'b0, q2_reg} - {1'b0, off};
        neg3_next = v[28];
        mag3_next = neg3_next ? 27'(-v) : v[26:0];
    end

    // Stage 4: whole estimate by reciprocal, low by at most one
    always_comb
    begin
        logic [47:0] prod;
        prod = {21'd0, mag3_reg} * {27'd0, MICRO_RECIP};
        w4_next = prod[RECIP_SHIFT +: 8];
    end

    // Stage 5: remainder against the estimate
    always_comb
    begin
        logic [27:0] wm;
        logic [26:0] r;
        wm = {20'd0, w4_reg} * {8'd0, MICRO_SCALE};
        r = mag4_reg - wm[26:0];
        r5_next = r[20:0];
    end

    // Stage 6: correct estimate, restore sign, zero on error
    always_comb
    begin
        logic [7:0]  w;
        logic [20:0] r;
        w = w5_reg;
        r = r5_reg;
        if (r >= {1'b0, MICRO_SCALE})
        begin
            w = w + 8'd1;
            r = r - {1'b0, MICRO_SCALE};
        end
        err6_next = err5_reg;
        if (err5_reg != ERR_OK)
        begin
            whole6_next = '0;
            micro6_next = '0;
        end
        else if (neg5_reg)
        begin
            whole6_next = -{1'b0, w};
            micro6_next = -r;
        end
        else
        begin
            whole6_next = {1'b0, w};
            micro6_next = r;
        end
    end

    // Advance payload where a stage takes a request
    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            kind0_reg <= s_axis_tuser;
            hi0_reg   <= s_axis_tdata[7:0];
            lo0_reg   <= s_axis_tdata[15:8];
            chk0_reg  <= s_axis_tdata[23:16];
        end
        if (take[1])
        begin
            err1_reg  <= err1_next;
            raw1_reg  <= raw1_next;
            kind1_reg <= kind0_reg;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
        end
        if (take[2])
        begin
            err2_reg  <= err1_reg;
            raw2_reg  <= raw1_reg;
            kind2_reg <= kind1_reg;
            q2_reg    <= q2_next;
        end
        if (take[3])
        begin
            err3_reg <= err2_reg;
            raw3_reg <= raw2_reg;
            neg3_reg <= neg3_next;
            mag3_reg <= mag3_next;
        end
        if (take[4])
        begin
            err4_reg <= err3_reg;
            raw4_reg <= raw3_reg;
            neg4_reg <= neg3_reg;
            mag4_reg <= mag3_reg;
            w4_reg   <= w4_next;
        end
        if (take[5])
        begin
            err5_reg <= err4_reg;
            raw5_reg <= raw4_reg;
            neg5_reg <= neg4_reg;
            w5_reg   <= w4_reg;
            r5_reg   <= r5_next;
        end
        if (take[6])
        begin
            err6_reg   <= err6_next;
            raw6_reg   <= raw5_reg;
            whole6_reg <= whole6_next;
            micro6_reg <= micro6_next;
        end
    end

    assign m_axis_tdata = {micro6_reg, whole6_reg, raw6_reg, err6_reg};

endmodule
`default_nettype wire

// ===== verif/humidity_temp_frame_check_convert_unit_tb.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_check_convert_unit_tb: frame check and convert bench
// Streams humidity and temperature frames into the unit and checks every
// result against a local CRC-8 and scaling calculation. Directed frames
// cover the corner cases. Random frames are mostly well formed, with some
// status and CRC errors mixed in. Both stream sides idle and stall.
// ----------------------------------------------------------------------------
module humidity_temp_frame_check_convert_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import htfc_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         LONG_HOLD   = 300;
    localparam int         TAIL_CYCLES = 20;
    localparam logic [7:0] GEN_POLY    = 8'h31;
    localparam longint     RAW_SPAN    = 65535;
    localparam longint     MILLION     = 1000000;
    localparam longint     RH_GAIN     = 125000000;
    localparam longint     RH_BIAS     = 6000000;
    localparam longint     DEGC_GAIN   = 175720000;
    localparam longint     DEGC_BIAS   = 46850000;

    typedef struct {
        logic       kind;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [7:0] check_byte;
    } frame_req_t;

    typedef struct {
        err_code_t          err;
        logic [15:0]        raw;
        logic signed [8:0]  whole;
        logic signed [20:0] micro;
    } frame_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    frame_req_t    frame_pending_q[$];
    frame_result_t result_expect_q[$];

    logic frame_taken    = 1'b0;
    logic hold_armed     = 1'b0;
    int   hold_count     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   cycle_count    = 0;
    int   mismatch_count = 0;
    int   frames_sent    = 0;
    int   results_seen   = 0;
    int   err_seen[3]    = '{0, 0, 0};

    humidity_temp_frame_check_convert_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // CRC-8 over the two data bytes, shifted one bit at a time
    function automatic logic [7:0] frame_crc(logic [7:0] hi, logic [7:0] lo);
        logic [15:0] msg;
        logic [7:0]  rem;
        msg = {hi, lo};
        rem = 8'h00;
        for (int i = 15; i >= 0; i--)
        begin
            if (rem[7] ^ msg[i])
                rem = {rem[6:0], 1'b0} ^ GEN_POLY;
            else
                rem = {rem[6:0], 1'b0};
        end
        return rem;
    endfunction

    // Status test, CRC test, then scale to micro-units and split
    function automatic frame_result_t convert_frame(frame_req_t f);
        frame_result_t r;
        longint        v;
        r.raw   = {f.data_high, f.data_low};
        r.whole = '0;
        r.micro = '0;
        if (f.data_low[1:0] == 2'b11)
            r.err = ERR_STATUS;
        else if (frame_crc(f.data_high, f.data_low) != f.check_byte)
            r.err = ERR_CRC;
        else
        begin
            r.err = ERR_OK;
            if (f.kind == KIND_HUM)
                v = (RH_GAIN * longint'(r.raw)) / RAW_SPAN - RH_BIAS;
            else
                v = (DEGC_GAIN * longint'(r.raw)) / RAW_SPAN - DEGC_BIAS;
            r.whole = 9'(v / MILLION);
            r.micro = 21'(v % MILLION);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_frame(logic kind, logic [7:0] hi, logic [7:0] lo, logic [7:0] chk);
        frame_req_t f;
        f.kind       = kind;
        f.data_high  = hi;
        f.data_low   = lo;
        f.check_byte = chk;
        frame_pending_q.push_back(f);
    endtask

    task automatic add_good_frame(logic kind, logic [7:0] hi, logic [7:0] lo);
        add_frame(kind, hi, lo, frame_crc(hi, lo));
    endtask

    // Mostly well-formed frames, the rest status errors and bad checks
    task automatic add_random_frame();
        int         pick;
        logic       kind;
        logic [7:0] hi;
        logic [7:0] lo;
        pick = $urandom_range(99);
        kind = 1'($urandom_range(1));
        hi   = 8'($urandom);
        lo   = 8'($urandom);
        if (pick < 75)
        begin
            if (lo[1:0] == 2'b11)
                lo[1:0] = 2'($urandom_range(2));
            add_good_frame(kind, hi, lo);
        end
        else if (pick < 85)
        begin
            lo[1:0] = 2'b11;
            add_frame(kind, hi, lo, 8'($urandom));
        end
        else if (pick < 95)
        begin
            if (lo[1:0] == 2'b11)
                lo[1:0] = 2'($urandom_range(2));
            add_frame(kind, hi, lo, frame_crc(hi, lo) ^ 8'($urandom_range(255, 1)));
        end
        else
            add_frame(kind, hi, lo, 8'($urandom));
    endtask

    task automatic wait_all_sent();
        while (frame_pending_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (result_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            add_random_frame();
        wait_all_sent();
        wait_results_drained();
    endtask

    // Sender: hold a request until taken, then offer the next or idle
    always @(negedge clk)
    begin
        frame_req_t nxt;
        if (rst_n && !(s_axis_tvalid && !frame_taken))
        begin
            if (frame_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = frame_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.check_byte, nxt.data_low, nxt.data_high};
                s_axis_tuser  <= nxt.kind;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: one long hold-off when armed, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_armed && hold_count < LONG_HOLD)
        begin
            m_axis_tready <= 1'b0;
            hold_count    <= hold_count + 1;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: record accepted frames, check results in order
    always @(posedge clk)
    begin
        frame_req_t    f;
        frame_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            frame_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                f.kind       = s_axis_tuser;
                f.data_high  = s_axis_tdata[7:0];
                f.data_low   = s_axis_tdata[15:8];
                f.check_byte = s_axis_tdata[23:16];
                result_expect_q.push_back(convert_frame(f));
                frames_sent++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (result_expect_q.size() == 0)
                    report_mismatch("result with no frame pending",
                                    longint'(m_axis_tdata), longint'(0));
                else
                begin
                    want = result_expect_q.pop_front();
                    err_seen[want.err]++;
                    if (m_axis_tdata[1:0] != want.err)
                        report_mismatch("error_code", longint'(m_axis_tdata[1:0]),
                                        longint'(want.err));
                    if (m_axis_tdata[17:2] != want.raw)
                        report_mismatch("raw_word", longint'(m_axis_tdata[17:2]),
                                        longint'(want.raw));
                    if (m_axis_tdata[26:18] != want.whole)
                        report_mismatch("whole_part", longint'(m_axis_tdata[26:18]),
                                        longint'(want.whole));
                    if (m_axis_tdata[47:27] != want.micro)
                        report_mismatch("micro_part", longint'(m_axis_tdata[47:27]),
                                        longint'(want.micro));
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: range ends, zero crossings, status and CRC errors
        add_good_frame(KIND_HUM, 8'h00, 8'h00);
        add_good_frame(KIND_TEMP, 8'h00, 8'h00);
        add_good_frame(KIND_HUM, 8'hFF, 8'hFC);
        add_good_frame(KIND_TEMP, 8'hFF, 8'hFC);
        add_good_frame(KIND_HUM, 8'hFF, 8'hFE);
        add_good_frame(KIND_TEMP, 8'hFF, 8'hFD);
        add_good_frame(KIND_HUM, 8'h0C, 8'h49);
        add_good_frame(KIND_HUM, 8'h0C, 8'h4A);
        add_good_frame(KIND_TEMP, 8'h44, 8'h40);
        add_good_frame(KIND_TEMP, 8'h44, 8'h41);
        add_good_frame(KIND_HUM, 8'h80, 8'h00);
        add_good_frame(KIND_TEMP, 8'h7F, 8'hFE);
        add_frame(KIND_HUM, 8'h00, 8'h03, 8'h00);
        add_frame(KIND_TEMP, 8'hFF, 8'hFF, frame_crc(8'hFF, 8'hFF));
        add_frame(KIND_HUM, 8'h5A, 8'hA7, frame_crc(8'h5A, 8'hA7));
        add_frame(KIND_HUM, 8'h00, 8'h00, 8'hFF);
        add_frame(KIND_TEMP, 8'h00, 8'h00, 8'h01);
        add_frame(KIND_HUM, 8'hA5, 8'h5C, frame_crc(8'hA5, 8'h5C) ^ 8'h01);
        add_frame(KIND_TEMP, 8'hA5, 8'h5C, frame_crc(8'hA5, 8'h5C) ^ 8'h80);
        add_frame(KIND_TEMP, 8'hFF, 8'hFC, 8'h00);
        add_frame(KIND_HUM, 8'h12, 8'h34, 8'hFF);
        wait_all_sent();
        wait_results_drained();

        run_random_phase(0, 0, 80);
        run_random_phase(63, 0, 80);
        run_random_phase(0, 63, 80);
        run_random_phase(33, 33, 80);

        // Back up the output while the sender keeps offering frames
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        run_random_phase(0, 0, 80);
        hold_armed     = 1'b0;

        wait_all_sent();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d frames in %0d cycles",
                 results_seen, frames_sent, cycle_count);
        $display("Results by code: ok %0d, status error %0d, CRC mismatch %0d",
                 err_seen[ERR_OK], err_seen[ERR_STATUS], err_seen[ERR_CRC]);
        if (mismatch_count == 0 && result_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== humidity_temp_frame_check_convert_unit.f =====
hw/rtl/htfc_pkg.sv
hw/rtl/humidity_temp_frame_check_convert_unit.sv
verif/humidity_temp_frame_check_convert_unit_tb.sv
